FILE: rtl/rrra_pkg.sv
// Package for the round-robin resource allocator: word types, mode and
// register codes, sequencer states. No dependencies.
`timescale 1ns / 1ps

package rrra_pkg;

  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [2:0] MODE_TAKE_THREADS = 3'd0;
  localparam logic [2:0] MODE_FREE_THREADS = 3'd1;
  localparam logic [2:0] MODE_TAKE_PORT    = 3'd2;
  localparam logic [2:0] MODE_FREE_PORT    = 3'd3;
  localparam logic [2:0] MODE_QUERY_SLOT   = 3'd4;
  localparam logic [2:0] MODE_OCCUPY_SLOT  = 3'd5;
  localparam logic [2:0] MODE_FREE_SLOT    = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_CORE_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PORT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREPROC_LIMIT = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [9:0]  thread_request;
    logic [15:0] port_to_free;
    logic [63:0] available_mask;
  } in_word_t;

  typedef struct packed {
    logic        granted;
    logic [15:0] port_number;
    logic [9:0]  threads_in_use;
    logic [7:0]  slots_active;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRAP,
    ST_SCAN
  } state_e;

endpackage

FILE: rtl/round_robin_resource_allocator.sv
// Round-robin resource allocator: thread credits, port pool, slot counter.
// Depends on rrra_pkg.
//
// Usage: one input word per request on in_valid_i/in_stall_o/in_word_i, one
// result word per request on out_valid_o/out_stall_i/out_word_o. A word moves
// at a clock edge with valid high and stall low. Registers are written on
// cfg_we_i with cfg_index_i and cfg_data_i; the user must write them only
// while no request is in flight, as the block itself does not enforce this.
// Every request except a take-port on a non-empty pool gives its result in
// the cycle after acceptance. A take-port request on a non-empty pool first
// reduces the round-robin pointer into the pool in ST_WRAP (one subtract of
// the pool size per cycle, needed when the pool shrank), then tests one pool
// entry per cycle in ST_SCAN with a single compare and increment unit, up to
// min(pool_count, POOL_DEPTH) entries. One request is in flight at a time.
// A finished result sits in the output register until taken; while it is
// stalled no new word is accepted. Reset clears the configuration registers,
// the busy map, the counters and the pointer, and leaves the output empty.
`timescale 1ns / 1ps

module round_robin_resource_allocator
  import rrra_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam logic [6:0] DEPTH7 = 7'(POOL_DEPTH);

  state_e state_q, state_d;

  logic [9:0]  core_limit_q;
  logic [15:0] first_port_q;
  logic [6:0]  pool_count_q;
  logic [7:0]  preproc_limit_q;

  logic [9:0]            thr_q, thr_d;
  logic [7:0]            slot_q, slot_d;
  logic [POOL_DEPTH-1:0] busy_q, busy_d;
  logic [IDX_W-1:0]      next_q, next_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [6:0]            cnt_q, cnt_d;
  logic [POOL_DEPTH-1:0] mask_q, mask_d;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_q, out_d;

  logic        in_acc;
  logic [6:0]  pool_n;
  logic [6:0]  idx7;
  logic [6:0]  idx_inc7;
  logic [IDX_W-1:0] idx_wrap;
  logic        scan_hit;
  logic        scan_last;
  logic        wrap_done;
  logic [10:0] thr_sum;
  logic [15:0] free_off;

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign pool_n    = (pool_count_q > DEPTH7) ? DEPTH7 : pool_count_q;
  assign idx7      = 7'(idx_q);
  assign idx_inc7  = idx7 + 7'd1;
  assign idx_wrap  = (idx_inc7 == pool_n) ? '0 : IDX_W'(idx_inc7);
  assign scan_hit  = !busy_q[idx_q] && mask_q[idx_q];
  assign scan_last = (cnt_q + 7'd1) == pool_n;
  assign wrap_done = idx7 < pool_n;
  assign thr_sum   = {1'b0, thr_q} + {1'b0, in_word_i.thread_request};
  assign free_off  = in_word_i.port_to_free - first_port_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_limit_q    <= '0;
      first_port_q    <= '0;
      pool_count_q    <= '0;
      preproc_limit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CORE_LIMIT:    core_limit_q    <= cfg_data_i[9:0];
        CFG_FIRST_PORT:    first_port_q    <= cfg_data_i[15:0];
        CFG_POOL_COUNT:    pool_count_q    <= cfg_data_i[6:0];
        CFG_PREPROC_LIMIT: preproc_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_word_i.mode == MODE_TAKE_PORT && pool_n != 7'd0) begin
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (wrap_done) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    thr_d       = thr_q;
    slot_d      = slot_q;
    busy_d      = busy_q;
    next_d      = next_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_d.granted     = 1'b0;
          out_d.port_number = '0;
          out_valid_d       = 1'b1;
          case (in_word_i.mode)
            MODE_TAKE_THREADS: begin
              if (thr_sum <= {1'b0, core_limit_q}) begin
                thr_d         = thr_sum[9:0];
                out_d.granted = 1'b1;
              end
            end
            MODE_FREE_THREADS: begin
              thr_d = (in_word_i.thread_request >= thr_q) ? '0 :
                      thr_q - in_word_i.thread_request;
            end
            MODE_TAKE_PORT: begin
              if (pool_n != 7'd0) begin
                out_valid_d = 1'b0;
                idx_d       = next_q;
                cnt_d       = '0;
                mask_d      = in_word_i.available_mask[POOL_DEPTH-1:0];
              end
            end
            MODE_FREE_PORT: begin
              if (free_off < {9'd0, pool_n}) begin
                busy_d[free_off[IDX_W-1:0]] = 1'b0;
              end
            end
            MODE_QUERY_SLOT: out_d.granted = slot_q < preproc_limit_q;
            MODE_OCCUPY_SLOT: begin
              if (slot_q != 8'hFF) slot_d = slot_q + 8'd1;
            end
            MODE_FREE_SLOT: begin
              if (slot_q != 8'd0) slot_d = slot_q - 8'd1;
            end
            default: ;
          endcase
          out_d.threads_in_use = thr_d;
          out_d.slots_active   = slot_d;
        end
      end
      ST_WRAP: begin
        if (!wrap_done) begin
          idx_d = IDX_W'(idx7 - pool_n);
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          busy_d[idx_q]     = 1'b1;
          next_d            = idx_wrap;
          out_d.granted     = 1'b1;
          out_d.port_number = first_port_q + 16'(idx_q);
          out_valid_d       = 1'b1;
        end else begin
          idx_d = idx_wrap;
          cnt_d = cnt_q + 7'd1;
          if (scan_last) begin
            out_d.granted     = 1'b0;
            out_d.port_number = '0;
            out_valid_d       = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= '0;
      slot_q      <= '0;
      busy_q      <= '0;
      next_q      <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      thr_q       <= thr_d;
      slot_q      <= slot_d;
      busy_q      <= busy_d;
      next_q      <= next_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    out_q  <= out_d;
  end

  a_scan_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_WRAP) |-> !out_valid_q)
    else $error("result pending during port scan");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q < pool_n && idx7 < pool_n))
    else $error("scan index or count outside pool");

  a_hit_marks_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && scan_hit) |=> busy_q[$past(idx_q)] && out_valid_q)
    else $error("granted entry not marked busy");

  a_slot_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(slot_q) && $stable(thr_q))
    else $error("counter changed without a request");

endmodule
